// File: rtl/srr_pkg.sv
`timescale 1ns / 1ps

package srr_pkg;

  localparam int SEQ_SPACE   = 16;
  localparam int SEQ_W       = $clog2(SEQ_SPACE);
  localparam int MAX_DRAIN   = 8;
  localparam int CNT_W       = $clog2(MAX_DRAIN + 1);
  localparam int WIN_W       = 4;
  localparam int REF_W       = 16;
  localparam int LEN_W       = 8;

  localparam logic [LEN_W-1:0] MAX_PAYLOAD = LEN_W'(128);
  localparam logic [WIN_W-1:0] WIN_RESET   = WIN_W'(8);
  // window bound: min(MAX_DRAIN, SEQ_SPACE/2)
  localparam int               WIN_LIM_I   = (SEQ_SPACE / 2 < MAX_DRAIN) ?
                                             SEQ_SPACE / 2 : MAX_DRAIN;
  localparam logic [WIN_W-1:0] WIN_LIM     = WIN_W'(WIN_LIM_I);

  localparam logic KIND_DELIVER = 1'b0;
  localparam logic KIND_ACK     = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STORE,
    ST_DRAIN,
    ST_ACK
  } state_t;

  typedef struct packed {
    logic latch;    // capture the incoming item
    logic store;    // write the item into its slot
    logic deliver;  // emit head slot, advance expected number
    logic ack;      // emit acknowledgement
  } cmd_t;

  typedef struct packed {
    logic pkt_ok;     // captured item passed its checksum
    logic in_window;  // captured number lies in the receive window
    logic can_drain;  // head slot full and drain budget left
  } status_t;

  function automatic logic [WIN_W-1:0] eff_window(input logic [WIN_W-1:0] w);
    logic [WIN_W-1:0] r;
    r = w;
    if (r == '0) r = WIN_W'(1);
    if (r > WIN_LIM) r = WIN_LIM;
    return r;
  endfunction

endpackage

// File: rtl/srr_ctrl.sv
`timescale 1ns / 1ps

module srr_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  srr_pkg::status_t status,
  output srr_pkg::cmd_t    cmd,
  output logic             busy
);

  srr_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= srr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      srr_pkg::ST_IDLE: begin
        if (start) state_next = srr_pkg::ST_STORE;
      end
      srr_pkg::ST_STORE: begin
        if (!status.pkt_ok) state_next = srr_pkg::ST_IDLE;
        else if (status.in_window) state_next = srr_pkg::ST_DRAIN;
        else state_next = srr_pkg::ST_ACK;
      end
      srr_pkg::ST_DRAIN: begin
        if (!status.can_drain) state_next = srr_pkg::ST_ACK;
      end
      srr_pkg::ST_ACK: begin
        state_next = srr_pkg::ST_IDLE;
      end
      default: state_next = srr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state)
      srr_pkg::ST_IDLE: begin
        busy      = 1'b0;
        cmd.latch = start;
      end
      srr_pkg::ST_STORE: begin
        cmd.store = status.pkt_ok && status.in_window;
      end
      srr_pkg::ST_DRAIN: begin
        cmd.deliver = status.can_drain;
      end
      srr_pkg::ST_ACK: begin
        cmd.ack = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

// File: rtl/srr_datapath.sv
`timescale 1ns / 1ps

module srr_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  srr_pkg::cmd_t                   cmd,
  output srr_pkg::status_t                status,
  input  logic [srr_pkg::SEQ_W-1:0]       seq_num,
  input  logic                            checksum_ok,
  input  logic [srr_pkg::REF_W-1:0]       payload_ref,
  input  logic [srr_pkg::LEN_W-1:0]       payload_len,
  input  logic                            cfg_wr,
  input  logic [srr_pkg::WIN_W-1:0]       cfg_data,
  output logic                            out_valid,
  output logic                            kind,
  output logic [srr_pkg::SEQ_W-1:0]       out_seq,
  output logic [srr_pkg::REF_W-1:0]       out_ref,
  output logic [srr_pkg::LEN_W-1:0]       out_len,
  output logic                            last
);

  logic [srr_pkg::WIN_W-1:0]     window;
  logic [srr_pkg::SEQ_W-1:0]     expected;
  logic [srr_pkg::SEQ_SPACE-1:0] slot_full;
  logic [srr_pkg::REF_W-1:0]     slot_ref [srr_pkg::SEQ_SPACE];
  logic [srr_pkg::LEN_W-1:0]     slot_len [srr_pkg::SEQ_SPACE];
  logic [srr_pkg::CNT_W-1:0]     drain_cnt;

  logic [srr_pkg::SEQ_W-1:0]     pkt_seq;
  logic                          pkt_ok;
  logic [srr_pkg::REF_W-1:0]     pkt_ref;
  logic [srr_pkg::LEN_W-1:0]     pkt_len;

  logic [srr_pkg::SEQ_W-1:0]     seq_off;
  logic [srr_pkg::WIN_W-1:0]     win_eff;

  // distance wraps naturally in the sequence width
  assign seq_off = pkt_seq - expected;
  assign win_eff = srr_pkg::eff_window(window);

  assign status.pkt_ok    = pkt_ok;
  assign status.in_window = ({{(srr_pkg::WIN_W){1'b0}}, seq_off} <
                             {{(srr_pkg::SEQ_W){1'b0}}, win_eff});
  assign status.can_drain = slot_full[expected] &&
                            (drain_cnt != srr_pkg::CNT_W'(srr_pkg::MAX_DRAIN));

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      window    <= srr_pkg::WIN_RESET;
      expected  <= '0;
      slot_full <= '0;
      drain_cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr) window <= cfg_data;
      if (cmd.latch) drain_cnt <= '0;
      if (cmd.store) slot_full[pkt_seq] <= 1'b1;
      if (cmd.deliver) begin
        slot_full[expected] <= 1'b0;
        expected            <= expected + srr_pkg::SEQ_W'(1);
        drain_cnt           <= drain_cnt + srr_pkg::CNT_W'(1);
      end
      out_valid <= cmd.deliver || cmd.ack;
    end
  end

  // captured item, length clamped on entry
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      pkt_seq <= seq_num;
      pkt_ok  <= checksum_ok;
      pkt_ref <= payload_ref;
      pkt_len <= (payload_len > srr_pkg::MAX_PAYLOAD) ? srr_pkg::MAX_PAYLOAD
                                                      : payload_len;
    end
  end

  // slot payload store
  always_ff @(posedge clk) begin
    if (cmd.store) begin
      slot_ref[pkt_seq] <= pkt_ref;
      slot_len[pkt_seq] <= pkt_len;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.deliver) begin
      kind    <= srr_pkg::KIND_DELIVER;
      out_seq <= expected;
      out_ref <= slot_ref[expected];
      out_len <= slot_len[expected];
      last    <= 1'b0;
    end else if (cmd.ack) begin
      kind    <= srr_pkg::KIND_ACK;
      out_seq <= pkt_seq;
      out_ref <= '0;
      out_len <= '0;
      last    <= 1'b1;
    end
  end

  a_ack_zero: assert property (@(posedge clk) disable iff (rst)
    cmd.ack |=> out_valid && kind == srr_pkg::KIND_ACK && out_ref == '0 && out_len == '0)
    else $error("ack result carries payload");

  a_drain_bound: assert property (@(posedge clk) disable iff (rst)
    drain_cnt <= srr_pkg::CNT_W'(srr_pkg::MAX_DRAIN))
    else $error("drain count overran");

  a_deliver_adv: assert property (@(posedge clk) disable iff (rst)
    cmd.deliver |=> expected == $past(expected) + srr_pkg::SEQ_W'(1) &&
                    !slot_full[$past(expected)])
    else $error("delivery did not retire head slot");

  a_cmd_excl: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.latch, cmd.store, cmd.deliver, cmd.ack}))
    else $error("conflicting datapath commands");

endmodule

// File: rtl/selective_repeat_receiver.sv
`timescale 1ns / 1ps
// An accepted item is captured, window-checked and, if in window, stored; the drain
// then delivers 0 to 8 in-order slots, one per cycle, and the ack follows.
// An item out of window goes straight to the ack; a corrupt item frees the block
// with no result. A new item is taken only once the block is idle again.
// Reset (rst, synchronous, active high): expected number 0, all slots empty,
// window 8. Results cannot be stalled by the receiver.

module selective_repeat_receiver (
  input  logic                            clk,
  input  logic                            rst,
  // item channel
  input  logic                            start,
  output logic                            busy,
  input  logic [srr_pkg::SEQ_W-1:0]       seq_num,
  input  logic                            checksum_ok,
  input  logic [srr_pkg::REF_W-1:0]       payload_ref,
  input  logic [srr_pkg::LEN_W-1:0]       payload_len,
  // window size register
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [srr_pkg::WIN_W-1:0]       cfg_data,
  // results, one per cycle while out_valid is high
  output logic                            out_valid,
  output logic                            kind,
  output logic [srr_pkg::SEQ_W-1:0]       out_seq,
  output logic [srr_pkg::REF_W-1:0]       out_ref,
  output logic [srr_pkg::LEN_W-1:0]       out_len,
  output logic                            last
);

  srr_pkg::cmd_t    cmd;
  srr_pkg::status_t status;

  // The register is to be written only while idle; the block itself does not enforce it, so it is always ready.
  assign cfg_ready = 1'b1;

  // Controller: idle -> store (window check, slot write) -> drain (one delivery per
  // cycle while head slot full, budget left) -> ack; out of window: ack, corrupt: idle.
  srr_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  // Datapath: captured item, slot store, expected number, window
  // register and the registered result stage.
  srr_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .seq_num     (seq_num),
    .checksum_ok (checksum_ok),
    .payload_ref (payload_ref),
    .payload_len (payload_len),
    .cfg_wr      (cfg_valid && cfg_ready),
    .cfg_data    (cfg_data),
    .out_valid   (out_valid),
    .kind        (kind),
    .out_seq     (out_seq),
    .out_ref     (out_ref),
    .out_len     (out_len),
    .last        (last)
  );

  a_accept_capture: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not occupy the block");

  a_result_busy: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !last) |-> busy)
    else $error("delivery seen while idle");

  a_last_then_idle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last) |-> !busy)
    else $error("ack seen while still draining");

endmodule
